/* hw/rtl/lrut_pkg.sv */
// shared types and constants for the lru replacement tracker
`default_nettype none

package lrut_pkg;

  // field widths of the request and result words
  localparam int unsigned FRAME_W = 6;

  // default number of page frames tracked
  localparam int unsigned DEF_NUM_FRAMES = 64;

  // request codes
  localparam logic REQ_REFERENCE = 1'b0;
  localparam logic REQ_EVICT     = 1'b1;

  // request word
  typedef struct packed {
    logic               req_type;
    logic [FRAME_W-1:0] frame_index;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [FRAME_W-1:0] victim_frame;
    logic               victim_error;
  } out_word_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the request and read the link stores
    logic clear_step;  // clear one tracked bit during the sweep
    logic evict;       // remove the oldest frame and emit the result
    logic unlink;      // splice the referenced frame out of the list
    logic link;        // write the referenced frame's own links
    logic tail;        // point the old newest frame at the referenced frame
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // sweep is at its final entry
    logic is_evict;    // latched request is an evict
    logic in_range;    // latched frame is below the frame count
    logic tracked;     // latched frame is on the list
    logic is_newest;   // latched frame is the newest member
    logic list_empty;  // no frame is on the list
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/lrut_datapath.sv */
// link stores, list pointers and result register of the lru tracker
`default_nettype none

module lrut_datapath #(
  parameter int unsigned NUM_FRAMES = lrut_pkg::DEF_NUM_FRAMES
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire  lrut_pkg::cmd_t     cmd,
  output       lrut_pkg::status_t  status,
  input  wire  lrut_pkg::in_word_t request,
  output       lrut_pkg::out_word_t result,
  output       logic               done
);

  localparam int unsigned IDXW = $clog2(NUM_FRAMES);
  localparam int unsigned LW   = $clog2(NUM_FRAMES + 1);
  localparam logic [LW-1:0] LINK_NONE = LW'(NUM_FRAMES);

  // storage
  logic [LW-1:0] next_mem [NUM_FRAMES];
  logic [LW-1:0] prev_mem [NUM_FRAMES];
  logic          trk_mem  [NUM_FRAMES];

  // latched request and list pointers
  logic            req_type;
  logic [IDXW-1:0] frame;
  logic            in_range;
  logic [IDXW-1:0] oldest;
  logic [IDXW-1:0] newest;
  logic            list_empty;
  logic [IDXW-1:0] clr_cnt;

  // registered read data
  logic [LW-1:0] next_rd;
  logic [LW-1:0] prev_rd;
  logic          trk_rd;

  // request address and range check
  logic [31:0]     idx_wide;
  logic [IDXW-1:0] req_addr;
  logic [IDXW-1:0] rd_addr;
  logic            req_in_range;

  assign idx_wide     = 32'(request.frame_index);
  assign req_addr     = idx_wide[IDXW-1:0];
  assign req_in_range = idx_wide < NUM_FRAMES;
  assign rd_addr      = (request.req_type == lrut_pkg::REQ_EVICT) ? oldest : req_addr;

  // neighbours as frame numbers
  logic [IDXW-1:0] nx_idx;
  logic [IDXW-1:0] pv_idx;
  logic            pv_none;

  assign nx_idx  = next_rd[IDXW-1:0];
  assign pv_idx  = prev_rd[IDXW-1:0];
  assign pv_none = (prev_rd == LINK_NONE);

  // write port selection
  logic            next_we;
  logic [IDXW-1:0] next_wa;
  logic [LW-1:0]   next_wd;
  logic            prev_we;
  logic [IDXW-1:0] prev_wa;
  logic [LW-1:0]   prev_wd;
  logic            trk_we;
  logic [IDXW-1:0] trk_wa;
  logic            trk_wd;

  always_comb begin
    next_we = 1'b0;
    next_wa = frame;
    next_wd = LINK_NONE;
    prev_we = 1'b0;
    prev_wa = frame;
    prev_wd = LINK_NONE;
    trk_we  = 1'b0;
    trk_wa  = frame;
    trk_wd  = 1'b0;
    if (cmd.clear_step) begin
      trk_we = 1'b1;
      trk_wa = clr_cnt;
      trk_wd = 1'b0;
    end
    if (cmd.unlink) begin
      next_we = !pv_none;
      next_wa = pv_idx;
      next_wd = next_rd;
      prev_we = 1'b1;
      prev_wa = nx_idx;
      prev_wd = prev_rd;
    end
    if (cmd.link) begin
      next_we = 1'b1;
      next_wa = frame;
      next_wd = LINK_NONE;
      prev_we = 1'b1;
      prev_wa = frame;
      prev_wd = list_empty ? LINK_NONE : LW'(newest);
      trk_we  = 1'b1;
      trk_wa  = frame;
      trk_wd  = 1'b1;
    end
    if (cmd.tail) begin
      next_we = 1'b1;
      next_wa = newest;
      next_wd = LW'(frame);
    end
    if (cmd.evict && !list_empty) begin
      trk_we  = 1'b1;
      trk_wa  = oldest;
      trk_wd  = 1'b0;
      prev_we = (oldest != newest);
      prev_wa = nx_idx;
      prev_wd = LINK_NONE;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (trk_we) begin
      trk_mem[trk_wa] <= trk_wd;
    end
    if (cmd.capture) begin
      next_rd <= next_mem[rd_addr];
      prev_rd <= prev_mem[rd_addr];
      trk_rd  <= trk_mem[rd_addr];
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type <= request.req_type;
      frame    <= req_addr;
      in_range <= req_in_range;
    end
  end

  // list pointers, sweep counter and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      newest     <= '0;
      list_empty <= 1'b1;
      clr_cnt    <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.evict;
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + IDXW'(1);
      end
      if (cmd.unlink && pv_none) begin
        oldest <= nx_idx;
      end
      if (cmd.link && list_empty) begin
        oldest     <= frame;
        newest     <= frame;
        list_empty <= 1'b0;
      end
      if (cmd.tail) begin
        newest <= frame;
      end
      if (cmd.evict && !list_empty) begin
        if (oldest == newest) begin
          list_empty <= 1'b1;
          oldest     <= '0;
          newest     <= '0;
        end else begin
          oldest <= nx_idx;
        end
      end
    end
  end

  // result word
  logic [31:0] old_wide;
  assign old_wide = 32'(oldest);

  always_ff @(posedge clk) begin
    if (cmd.evict) begin
      result.victim_frame <= list_empty ? '0 : old_wide[lrut_pkg::FRAME_W-1:0];
      result.victim_error <= list_empty;
    end
  end

  // status to the controller
  assign status.clear_last = (32'(clr_cnt) == NUM_FRAMES - 1);
  assign status.is_evict   = (req_type == lrut_pkg::REQ_EVICT);
  assign status.in_range   = in_range;
  assign status.tracked    = trk_rd;
  assign status.is_newest  = (frame == newest);
  assign status.list_empty = list_empty;

endmodule

`default_nettype wire

/* hw/rtl/lrut_ctrl.sv */
// sequencing state machine of the lru tracker
`default_nettype none

module lrut_ctrl (
  input  wire                  logic clk,
  input  wire                  logic rst,
  input  wire                  logic start,
  input  wire  lrut_pkg::status_t    status,
  output       lrut_pkg::cmd_t       cmd,
  output       logic                 busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_UNLINK,
    S_LINK,
    S_TAIL
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (status.is_evict || !status.in_range) begin
          state_next = S_IDLE;
        end else if (status.tracked && status.is_newest) begin
          state_next = S_IDLE;
        end else if (status.tracked) begin
          state_next = S_UNLINK;
        end else begin
          state_next = S_LINK;
        end
      end
      S_UNLINK: state_next = S_LINK;
      S_LINK: begin
        state_next = status.list_empty ? S_IDLE : S_TAIL;
      end
      S_TAIL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && start;
    cmd.clear_step = (state == S_CLEAR);
    cmd.evict      = (state == S_LOOK) && status.is_evict;
    cmd.unlink     = (state == S_UNLINK);
    cmd.link       = (state == S_LINK);
    cmd.tail       = (state == S_TAIL);
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lru_replacement_tracker.sv */
// Exact LRU tracker over NUM_FRAMES page frames, kept as a doubly linked
// recency list in two link memories with one write port each. A word is
// taken when start is high and busy is low. After reset the block sweeps
// its tracked-bit memory, clearing every entry, with busy high. An evict,
// a reference to the newest frame or a frame out of range ends at the
// look-up state; a reference that fills an empty list adds a link step,
// any other reference to an untracked frame adds link and tail steps, and
// moving a tracked frame to the newest end adds unlink, link and tail
// steps; the longer cases are set by the sequence of writes through the
// next-link memory port. An evict gives one result word, on result with
// done high for exactly one cycle, registered from the look-up state; the
// receiver cannot hold it off. References give no result. Clearing any
// external in-use mark of the victim is the caller's job.
`default_nettype none

module lru_replacement_tracker #(
  parameter int unsigned NUM_FRAMES = lrut_pkg::DEF_NUM_FRAMES
) (
  input  wire                   logic clk,
  input  wire                   logic rst,
  input  wire                   logic start,
  output                        logic busy,
  input  wire  lrut_pkg::in_word_t    request,
  output       lrut_pkg::out_word_t   result,
  output                        logic done
);

  lrut_pkg::cmd_t    cmd;
  lrut_pkg::status_t status;

  // sequencer
  lrut_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // link stores and pointers
  lrut_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .request (request),
    .result  (result),
    .done    (done)
  );

endmodule

`default_nettype wire

/* hw/rtl/lrut_checker.sv */
// port-level checks of the lru tracker and their binding
`default_nettype none

module lrut_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire lrut_pkg::in_word_t  request,
  input wire lrut_pkg::out_word_t result,
  input wire logic                done
);

  // an error result carries frame zero
  assert property (@(posedge clk) disable iff (rst)
    done && result.victim_error |-> result.victim_frame == '0)
    else $error("error result with nonzero frame");

  // every accepted evict gives its word
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.req_type == lrut_pkg::REQ_EVICT |-> ##2 done)
    else $error("evict without result");

  // a reference gives no word in the slot where an evict gives one
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.req_type == lrut_pkg::REQ_REFERENCE |-> ##2 !done)
    else $error("result after a reference");

  // no word comes while the block is still busy with a request
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("block not busy after taking a word");

  // the clearing sweep follows reset
  assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("block ready straight after reset");

endmodule

bind lru_replacement_tracker lrut_checker u_lrut_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .result  (result),
  .done    (done)
);

`default_nettype wire

/* dv/lru_replacement_tracker_tb.sv */
// self-checking testbench for the lru replacement tracker
`timescale 1ns / 1ps

module lru_replacement_tracker_tb;

  localparam int unsigned NUM_FRAMES = lrut_pkg::DEF_NUM_FRAMES;
  localparam int TOTAL_WORDS = 630;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 12;

  typedef logic [lrut_pkg::FRAME_W:0] link_t;
  localparam link_t NO_LINK = link_t'(NUM_FRAMES);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  lrut_pkg::in_word_t  request = '0;
  lrut_pkg::out_word_t result;
  logic                done;

  // words waiting to be sent and victims waiting to come back
  lrut_pkg::in_word_t  pending_words[$];
  lrut_pkg::out_word_t victims_due[$];
  int                  words_total = 0;
  int                  words_taken = 0;
  int                  bad_words = 0;

  // driver scratch
  int                  gap_left = 0;
  int                  calm_left = 0;
  logic                take_now;
  lrut_pkg::in_word_t  next_word;

  // watchdog
  int                  quiet_cycles = 0;

  // recency list as the block should hold it
  logic      on_list [NUM_FRAMES];
  link_t     newer_of [NUM_FRAMES];
  link_t     older_of [NUM_FRAMES];
  int        lru_frame;
  int        mru_frame;
  logic      chain_empty;

  lru_replacement_tracker #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result(result),
    .done(done)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    bad_words++;
  endtask

  // put frame f on the most recent end; f must be off the list
  task automatic link_newest(input int f);
    newer_of[f] = NO_LINK;
    if (chain_empty) begin
      older_of[f] = NO_LINK;
      lru_frame = f;
      chain_empty = 1'b0;
    end else begin
      older_of[f] = link_t'(mru_frame);
      newer_of[mru_frame] = link_t'(f);
    end
    mru_frame = f;
    on_list[f] = 1'b1;
  endtask

  // apply one taken word to the recency list and note any victim it yields
  task automatic track_word(input lrut_pkg::in_word_t w);
    int                  f;
    int                  nx;
    int                  pv;
    lrut_pkg::out_word_t r;
    if (w.req_type == lrut_pkg::REQ_REFERENCE) begin
      f = w.frame_index;
      // frame numbers past the frame count are dropped
      if (f < NUM_FRAMES) begin
        if (!on_list[f]) begin
          link_newest(f);
        end else if (f != mru_frame) begin
          // splice out of the middle or the old end, then relink
          nx = newer_of[f];
          pv = older_of[f];
          if (nx < NUM_FRAMES) begin
            if (pv >= NUM_FRAMES) lru_frame = nx;
            else newer_of[pv] = link_t'(nx);
            older_of[nx] = link_t'(pv);
          end
          on_list[f] = 1'b0;
          link_newest(f);
        end
      end
    end else if (chain_empty) begin
      // nothing to evict
      r.victim_frame = '0;
      r.victim_error = 1'b1;
      victims_due.push_back(r);
    end else begin
      r.victim_frame = lru_frame[lrut_pkg::FRAME_W-1:0];
      r.victim_error = 1'b0;
      on_list[lru_frame] = 1'b0;
      if (lru_frame == mru_frame) begin
        // last frame gone, list back to its reset shape
        chain_empty = 1'b1;
        lru_frame = 0;
        mru_frame = 0;
      end else begin
        nx = newer_of[lru_frame];
        if (nx < NUM_FRAMES) begin
          lru_frame = nx;
          older_of[nx] = NO_LINK;
        end
      end
      victims_due.push_back(r);
    end
  endtask

  task automatic queue_ref(input int f);
    lrut_pkg::in_word_t w;
    w.req_type = lrut_pkg::REQ_REFERENCE;
    w.frame_index = f[lrut_pkg::FRAME_W-1:0];
    pending_words.push_back(w);
  endtask

  // evicts carry a random frame field, which the block ignores
  task automatic queue_evict();
    lrut_pkg::in_word_t w;
    w.req_type = lrut_pkg::REQ_EVICT;
    w.frame_index = lrut_pkg::FRAME_W'($urandom_range(0, 63));
    pending_words.push_back(w);
  endtask

  // idle cycles before the next word: mostly short, a few long, calm runs with none
  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // driver: hold each word until taken, then idle for a random gap
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      take_now = start && !busy;
      if (take_now) begin
        track_word(request);
        words_taken++;
        gap_left = pick_gap();
      end
      if (start && !take_now) begin
        // word still waiting for the block
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        request <= lrut_pkg::in_word_t'($urandom_range(0, 127));
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        start <= 1'b1;
        request <= next_word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every result word against the oldest victim due
  always @(posedge clk) begin
    if (!rst && done) begin
      if (victims_due.size() == 0) begin
        flag_mismatch($sformatf("result word frame %0d error %0b with none due",
                                result.victim_frame, result.victim_error));
      end else begin
        automatic lrut_pkg::out_word_t due = victims_due.pop_front();
        if (result.victim_frame !== due.victim_frame ||
            result.victim_error !== due.victim_error) begin
          flag_mismatch($sformatf("frame %0d error %0b, expected frame %0d error %0b",
                                  result.victim_frame, result.victim_error,
                                  due.victim_frame, due.victim_error));
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int pool [16];
    int pool_size;
    int len;
    int pct;
    int kind;

    for (int i = 0; i < NUM_FRAMES; i++) begin
      on_list[i] = 1'b0;
      newer_of[i] = NO_LINK;
      older_of[i] = NO_LINK;
    end
    lru_frame = 0;
    mru_frame = 0;
    chain_empty = 1'b1;

    // directed: empty list, single frame, moves from the old end and the middle
    queue_evict();
    queue_ref(0);
    queue_evict();
    queue_evict();
    queue_ref(63);
    queue_ref(0);
    queue_ref(63);
    queue_ref(63);
    queue_ref(32);
    queue_ref(63);
    queue_ref(21);
    queue_ref(42);
    queue_ref(32);
    queue_evict();
    queue_evict();
    queue_evict();
    queue_evict();
    queue_evict();
    queue_evict();
    queue_ref(42);
    queue_evict();

    // random bursts, mostly working sets with evicts mixed in
    while (pending_words.size() < TOTAL_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        case ($urandom_range(0, 5))
          0: pool_size = 1;
          1: pool_size = 2;
          2: pool_size = 3;
          3: pool_size = 5;
          4: pool_size = 8;
          default: pool_size = 16;
        endcase
        for (int i = 0; i < pool_size; i++) pool[i] = $urandom_range(0, 63);
        len = $urandom_range(10, 30);
        pct = $urandom_range(15, 40);
        repeat (len) begin
          if ($urandom_range(0, 99) < pct) queue_evict();
          else queue_ref(pool[$urandom_range(0, pool_size - 1)]);
        end
      end else if (kind <= 7) begin
        // spread over every frame to fill the list
        len = $urandom_range(30, 90);
        pct = $urandom_range(0, 10);
        repeat (len) begin
          if ($urandom_range(0, 99) < pct) queue_evict();
          else queue_ref($urandom_range(0, 63));
        end
      end else if (kind == 8) begin
        // drain, often past empty
        repeat ($urandom_range(5, 70)) queue_evict();
      end else begin
        // noise
        repeat ($urandom_range(5, 20)) begin
          if ($urandom_range(0, 1) == 0) queue_evict();
          else queue_ref($urandom_range(0, 63));
        end
      end
    end
    words_total = pending_words.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (words_taken < words_total || victims_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (bad_words == 0 && victims_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lrut_pkg.sv
hw/rtl/lrut_datapath.sv
hw/rtl/lrut_ctrl.sv
hw/rtl/lru_replacement_tracker.sv
hw/rtl/lrut_checker.sv
dv/lru_replacement_tracker_tb.sv
